// ===== hw/rtl/bdq_pkg.sv =====
// Shared types and constants for the bounded double-ended queue.
package bdq_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int DATA_W        = 32;
    localparam int CMD_W         = 3;
    localparam int STATUS_W      = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_START = 3'd0,
        CMD_PUSH_END   = 3'd1,
        CMD_POP_START  = 3'd2,
        CMD_POP_END    = 3'd3,
        CMD_LIST       = 3'd4
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_UNDER = 2'd1,
        ST_OVER  = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_PUSH_FRONT,
        OP_PUSH_BACK,
        OP_SHIFT_LEFT,
        OP_ROTATE
    } cell_op_t;

    typedef enum logic {
        S_IDLE,
        S_LIST
    } state_t;

    typedef struct packed {
        cell_op_t                  op;
        logic signed [DATA_W-1:0]  value;
    } cell_ctrl_t;

endpackage

// ===== hw/rtl/bdq_if.sv =====
// Valid/ready channel interfaces for commands and results.
interface bdq_req_if
    import bdq_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic [CMD_W-1:0]          cmd;
    logic signed [DATA_W-1:0]  value;

    modport source (output valid, output cmd, output value, input ready);
    modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface bdq_rsp_if
    import bdq_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic [STATUS_W-1:0]       status;
    logic signed [DATA_W-1:0]  data;
    logic                      last;

    modport source (output valid, output status, output data, output last, input ready);
    modport sink   (input valid, input status, input data, input last, output ready);
endinterface

// ===== hw/rtl/bdq_cell.sv =====
// One queue cell: holds an entry and trades it with its neighbors.
module bdq_cell
    import bdq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT,
    parameter int IDX   = 0
) (
    input  logic                              clk,
    input  cell_ctrl_t                        ctrl,
    input  logic [$clog2(DEPTH+1)-1:0]        count,
    input  logic signed [DATA_W-1:0]          left_data,
    input  logic signed [DATA_W-1:0]          right_data,
    input  logic signed [DATA_W-1:0]          head_data,
    output logic signed [DATA_W-1:0]          data,
    output logic signed [DATA_W-1:0]          tail_data
);

    localparam int CW = $clog2(DEPTH+1);

    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;
    logic                     is_fill;
    logic                     is_tail;

    assign is_fill = (count == CW'(IDX));
    assign is_tail = (count == CW'(IDX + 1));

    always_comb
    begin
        data_next = data_reg;
        unique case (ctrl.op)
            OP_HOLD:       data_next = data_reg;
            OP_PUSH_FRONT: data_next = left_data;
            OP_PUSH_BACK:  data_next = is_fill ? ctrl.value : data_reg;
            OP_SHIFT_LEFT: data_next = right_data;
            OP_ROTATE:     data_next = is_tail ? head_data : right_data;
            default:       data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data      = data_reg;
    assign tail_data = is_tail ? data_reg : '0;

endmodule

// ===== hw/rtl/bounded_double_ended_queue.sv =====
// Bounded double-ended queue built from a row of shifting cells.
//
//  channel | dir | payload             | transfer
//  req     | in  | cmd, value          | valid && ready
//  rsp     | out | status, data, last  | valid && ready
//
// Push and pop each give one result; list of a non-empty queue first enters the
// walk state, then gives one result per live entry (a single empty result when
// empty), rotating the cell row by one per result.
// Reset clears the walk state and fill count (the head is always cell 0); cell
// data is not reset. A result waits in the output register; when idle, a new
// command is taken in the cycle it frees; rsp stalls hold the list walk.
module bounded_double_ended_queue
    import bdq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    bdq_req_if.sink    req,
    bdq_rsp_if.source  rsp
);

    localparam int CW = $clog2(DEPTH+1);

    state_t                     state_reg,  state_next;
    logic [CW-1:0]              count_reg,  count_next;
    logic [CW-1:0]              list_reg,   list_next;
    logic                       rsp_valid_reg, rsp_valid_next;
    status_t                    status_reg, status_next;
    logic signed [DATA_W-1:0]   data_reg,   data_next;
    logic                       last_reg,   last_next;

    cell_ctrl_t                 ctrl;
    logic                       out_free;
    logic                       req_ready;
    logic                       load;
    logic signed [DATA_W-1:0]   cell_data [DEPTH];
    logic signed [DATA_W-1:0]   cell_tail [DEPTH];
    logic signed [DATA_W-1:0]   tail_value;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            bdq_cell #(
                .DEPTH (DEPTH),
                .IDX   (g)
            ) u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .count      (count_reg),
                .left_data  ((g == 0) ? req.value : cell_data[(g == 0) ? 0 : g-1]),
                .right_data (cell_data[(g == DEPTH-1) ? g : g+1]),
                .head_data  (cell_data[0]),
                .data       (cell_data[g]),
                .tail_data  (cell_tail[g])
            );
        end
    endgenerate

    always_comb
    begin
        tail_value = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            tail_value = tail_value | cell_tail[i];
        end
    end

    assign out_free = !rsp_valid_reg || rsp.ready;

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        list_next   = list_reg;
        ctrl.op     = OP_HOLD;
        ctrl.value  = req.value;
        req_ready   = 1'b0;
        load        = 1'b0;
        status_next = ST_OK;
        data_next   = '0;
        last_next   = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = out_free;
                if (req.valid && out_free)
                begin
                    unique case (req.cmd)
                        CMD_PUSH_START, CMD_PUSH_END:
                        begin
                            load = 1'b1;
                            if (count_reg == CW'(DEPTH))
                            begin
                                status_next = ST_OVER;
                            end
                            else
                            begin
                                ctrl.op    = (req.cmd == CMD_PUSH_START) ?
                                             OP_PUSH_FRONT : OP_PUSH_BACK;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        CMD_POP_START, CMD_POP_END:
                        begin
                            load = 1'b1;
                            if (count_reg == '0)
                            begin
                                status_next = ST_UNDER;
                            end
                            else
                            begin
                                count_next = count_reg - CW'(1);
                                if (req.cmd == CMD_POP_START)
                                begin
                                    ctrl.op   = OP_SHIFT_LEFT;
                                    data_next = cell_data[0];
                                end
                                else
                                begin
                                    data_next = tail_value;
                                end
                            end
                        end
                        CMD_LIST:
                        begin
                            if (count_reg == '0)
                            begin
                                load        = 1'b1;
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                list_next  = count_reg;
                                state_next = S_LIST;
                            end
                        end
                        default:
                        begin
                            load = 1'b0;
                        end
                    endcase
                end
            end
            S_LIST:
            begin
                if (out_free)
                begin
                    load      = 1'b1;
                    ctrl.op   = OP_ROTATE;
                    data_next = cell_data[0];
                    last_next = (list_reg == CW'(1));
                    list_next = list_reg - CW'(1);
                    if (list_reg == CW'(1))
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        rsp_valid_next = load || (rsp_valid_reg && !rsp.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            list_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            list_reg      <= list_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            status_reg <= status_next;
            data_reg   <= data_next;
            last_reg   <= last_next;
        end
    end

    assign req.ready  = req_ready;
    assign rsp.valid  = rsp_valid_reg;
    assign rsp.status = status_reg;
    assign rsp.data   = data_reg;
    assign rsp.last   = last_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("fill count above depth");

    a_list_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_LIST |-> !req.ready)
        else $error("command taken during list walk");

    a_underflow_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready && count_reg == '0 &&
         (req.cmd == CMD_POP_START || req.cmd == CMD_POP_END))
        |=> count_reg == '0)
        else $error("pop on empty queue changed count");

    a_overflow_keeps: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready && count_reg == CW'(DEPTH) &&
         (req.cmd == CMD_PUSH_START || req.cmd == CMD_PUSH_END))
        |=> count_reg == CW'(DEPTH))
        else $error("push on full queue changed count");

    a_partial_in_list: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.last) |-> state_reg == S_LIST)
        else $error("non-final result outside list walk");

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the bounded double-ended queue.
module tb_top;
    import bdq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH       = 16;
    localparam int ITEMS       = 210;
    localparam int QUIET_ITEMS = 40;
    localparam int HOLD_CYCLES = 60;
    localparam int DRAIN_WAIT  = 2 * DEPTH;
    localparam logic [CMD_W-1:0] CMD_UNUSED_LO  = 3'd5;
    localparam logic [CMD_W-1:0] CMD_UNUSED_MID = 3'd6;
    localparam logic [CMD_W-1:0] CMD_UNUSED_HI  = 3'd7;

    typedef struct packed {
        status_t                   status;
        logic signed [DATA_W-1:0]  data;
        logic                      last;
    } result_t;

    class deque_scoreboard;
        logic signed [DATA_W-1:0] ring [DEPTH];
        int       head;
        int       live;
        int       errors;
        result_t  awaited [$];

        function new();
            head   = 0;
            live   = 0;
            errors = 0;
        endfunction

        task report(input string msg);
            errors++;
            if (errors <= 30)
                $display("ERROR @%0t: %s", $realtime, msg);
        endtask

        function void queue_result(status_t st, logic signed [DATA_W-1:0] d, logic l);
            result_t r;
            r.status = st;
            r.data   = d;
            r.last   = l;
            awaited.push_back(r);
        endfunction

        function int outstanding();
            return awaited.size();
        endfunction

        // Predict the results of one accepted command.
        function void note_command(logic [CMD_W-1:0] code, logic signed [DATA_W-1:0] v);
            case (code)
                CMD_PUSH_START, CMD_PUSH_END:
                begin
                    if (live >= DEPTH)
                        queue_result(ST_OVER, '0, 1'b1);
                    else
                    begin
                        if (code == CMD_PUSH_START)
                        begin
                            head = (head + DEPTH - 1) % DEPTH;
                            ring[head] = v;
                        end
                        else
                            ring[(head + live) % DEPTH] = v;
                        live++;
                        queue_result(ST_OK, '0, 1'b1);
                    end
                end
                CMD_POP_START:
                begin
                    if (live == 0)
                        queue_result(ST_UNDER, '0, 1'b1);
                    else
                    begin
                        queue_result(ST_OK, ring[head], 1'b1);
                        head = (head + 1) % DEPTH;
                        live--;
                    end
                end
                CMD_POP_END:
                begin
                    if (live == 0)
                        queue_result(ST_UNDER, '0, 1'b1);
                    else
                    begin
                        queue_result(ST_OK, ring[(head + live - 1) % DEPTH], 1'b1);
                        live--;
                    end
                end
                CMD_LIST:
                begin
                    if (live == 0)
                        queue_result(ST_EMPTY, '0, 1'b1);
                    else
                        for (int i = 0; i < live; i++)
                            queue_result(ST_OK, ring[(head + i) % DEPTH], i == live - 1);
                end
                default: ;
            endcase
        endfunction

        task check_result(status_t st, logic signed [DATA_W-1:0] d, logic l);
            result_t e;
            if (awaited.size() == 0)
            begin
                report($sformatf("unexpected result status=%s data=%0d last=%0b",
                                 st.name(), d, l));
                return;
            end
            e = awaited.pop_front();
            if (st !== e.status)
                report($sformatf("status %s, predicted %s", st.name(), e.status.name()));
            if (d !== e.data)
                report($sformatf("data %0d, predicted %0d", d, e.data));
            if (l !== e.last)
                report($sformatf("last %0b, predicted %0b", l, e.last));
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;

    bdq_req_if req ();
    bdq_rsp_if rsp ();

    bounded_double_ended_queue #(.DEPTH(DEPTH)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    deque_scoreboard sb;
    bit idling_on     = 1'b1;
    bit rsp_hold_req  = 1'b0;
    int commands_done = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'sh7fff_ffff;
            1: return 32'sh8000_0000;
            2: return '0;
            3: return -32'sd1;
            default: return $urandom();
        endcase
    endfunction

    task automatic issue_command(input logic [CMD_W-1:0] code,
                                 input logic signed [DATA_W-1:0] v);
        if (idling_on && $urandom_range(0, 3) == 0)
        begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        req.valid <= 1'b1;
        req.cmd   <= code;
        req.value <= v;
        do
            @(posedge clk);
        while (!req.ready);
        sb.note_command(code, v);
        if (code <= CMD_LIST)
            commands_done++;
    endtask

    task automatic issue_push(input logic signed [DATA_W-1:0] v);
        issue_command($urandom_range(0, 1) ? CMD_PUSH_START : CMD_PUSH_END, v);
    endtask

    task automatic issue_pop();
        issue_command($urandom_range(0, 1) ? CMD_POP_START : CMD_POP_END, '0);
    endtask

    task automatic mixed_round(input int push_pct);
        int r;
        repeat (30)
        begin
            r = $urandom_range(0, 99);
            if (r < push_pct)
                issue_push(pick_value());
            else if (r < 90)
                issue_pop();
            else if (r < 97)
                issue_command(CMD_LIST, pick_value());
            else
                issue_command(CMD_W'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI)),
                              pick_value());
        end
    endtask

    // Receiver: random stalls, plus one long hold-off on request.
    initial
    begin
        rsp.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rsp_hold_req)
            begin
                rsp.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                rsp_hold_req = 1'b0;
                rsp.ready <= 1'b1;
            end
            else if (idling_on && $urandom_range(0, 3) == 0)
            begin
                rsp.ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
                rsp.ready <= 1'b1;
            end
            else
                rsp.ready <= 1'b1;
        end
    end

    always @(posedge clk)
        if (rst_n && rsp.valid && rsp.ready)
            sb.check_result(status_t'(rsp.status), rsp.data, rsp.last);

    initial
    begin
        #500_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        sb = new();
        rst_n     <= 1'b0;
        req.valid <= 1'b0;
        req.cmd   <= CMD_PUSH_START;
        req.value <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty queue corner cases, extremes, unused codes
        issue_command(CMD_LIST, '0);
        issue_command(CMD_POP_START, '0);
        issue_command(CMD_POP_END, -32'sd1);
        issue_command(CMD_PUSH_START, 32'sh7fff_ffff);
        issue_command(CMD_PUSH_END, 32'sh8000_0000);
        issue_command(CMD_PUSH_START, -32'sd1);
        issue_command(CMD_PUSH_END, '0);
        issue_command(CMD_LIST, 32'sh5555_aaaa);
        issue_command(CMD_UNUSED_LO, 32'sh1234_5678);
        issue_command(CMD_UNUSED_MID, '0);
        issue_command(CMD_UNUSED_HI, -32'sd1);
        issue_command(CMD_POP_START, '0);
        issue_command(CMD_POP_END, '0);
        issue_command(CMD_POP_START, '0);
        issue_command(CMD_POP_END, '0);
        issue_command(CMD_POP_START, '0);
        issue_command(CMD_LIST, '0);

        // fill past full under a long receiver hold-off, list, then drain past empty
        rsp_hold_req = 1'b1;
        repeat (DEPTH + 2) issue_push(pick_value());
        issue_command(CMD_LIST, '0);
        repeat (DEPTH + 1) issue_pop();

        while (commands_done < ITEMS - QUIET_ITEMS)
            mixed_round($urandom_range(0, 1) ? 75 : 30);

        idling_on = 1'b0;
        while (commands_done < ITEMS)
            mixed_round(55);
        issue_command(CMD_LIST, '0);
        req.valid <= 1'b0;

        while (sb.outstanding() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (sb.outstanding() != 0)
            sb.report($sformatf("%0d results never arrived", sb.outstanding()));

        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
